>>> sv/xeu_pkg.sv
// Shared constants, types and helper functions for the XML entity decoder.
package xeu_pkg;

  localparam int SPAN  = 10;
  localparam int IDXW  = $clog2(SPAN);
  localparam int CNTW  = $clog2(SPAN + 1);
  localparam int KW    = $clog2(SPAN + 2);
  localparam int NAMES = 5;

  localparam logic [32:0] CODE_LIMIT = 33'h110000;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;

  typedef struct packed {
    logic       clr;
    logic       en;
    logic       hex;
    logic [7:0] data;
  } num_req_t;

  typedef struct packed {
    logic        any;
    logic        neg;
    logic        ovf;
    logic [32:0] value;
  } num_res_t;

  typedef struct packed {
    logic       emit;
    logic       flush;
    logic       last;
    logic [7:0] data;
  } out_req_t;

  function automatic logic [2:0] name_len(input logic [2:0] i);
    logic [2:0] r;
    unique case (i)
      3'd0:    r = 3'd3;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd4;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] name_char(input logic [2:0] i, input logic [1:0] k);
    logic [31:0] s;
    unique case (i)
      3'd0:    s = {"amp", 8'h00};
      3'd1:    s = {"lt", 16'h0000};
      3'd2:    s = {"gt", 16'h0000};
      3'd3:    s = "quot";
      default: s = "apos";
    endcase
    return s[8*(3 - int'(k)) +: 8];
  endfunction

  function automatic logic [7:0] name_out(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h26;
      3'd1:    r = 8'h3C;
      3'd2:    r = 8'h3E;
      3'd3:    r = 8'h22;
      default: r = 8'h27;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] r;
    priority if (cp < 21'h80) r = 3'd1;
    else if (cp < 21'h800) r = 3'd2;
    else if (cp < 21'h10000) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (len)
      3'd1: r = cp[7:0];
      3'd2: r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        unique case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        unique case (idx)
          2'd0:    r = {5'b11110, cp[20:18]};
          2'd1:    r = {2'b10, cp[17:12]};
          2'd2:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

>>> sv/xeu_num.sv
// Numeric reference parser: one character per cycle through a shared digit accumulator.
module xeu_num import xeu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  num_req_t req_i,
  output num_res_t res_o
);

  localparam logic [2:0] P_BL   = 3'd0;
  localparam logic [2:0] P_PRE  = 3'd1;
  localparam logic [2:0] P_Z0   = 3'd2;
  localparam logic [2:0] P_ZX   = 3'd3;
  localparam logic [2:0] P_DIG  = 3'd4;
  localparam logic [2:0] P_DONE = 3'd5;

  logic [2:0]  p_q, p_d;
  logic [32:0] v_q, v_d;
  logic        any_q, any_d, neg_q, neg_d;

  logic [7:0]  c;
  logic [4:0]  dv;
  logic        blank, isdig, isx, do_pre;
  logic [36:0] prod, sum;
  logic [32:0] sat;

  always_comb begin
    c = req_i.data;
    priority if (c >= 8'h30 && c <= 8'h39) dv = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) dv = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) dv = 5'(c - 8'h37);
    else dv = 5'd31;
    blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    isdig = req_i.hex ? (dv < 5'd16) : (dv < 5'd10);
    isx   = (c == CH_LX) || (c == CH_UX);
    prod  = req_i.hex ? {v_q, 4'b0000} : (37'({v_q, 3'b000}) + 37'({v_q, 1'b0}));
    sum   = prod + 37'(dv);
    sat   = (sum > 37'h100000000) ? 33'h100000000 : sum[32:0];
  end

  always_comb begin
    p_d    = p_q;
    v_d    = v_q;
    any_d  = any_q;
    neg_d  = neg_q;
    do_pre = 1'b0;
    if (req_i.clr) begin
      p_d   = P_BL;
      v_d   = '0;
      any_d = 1'b0;
      neg_d = 1'b0;
    end else if (req_i.en) begin
      unique case (p_q)
        P_BL: begin
          if (blank) begin
            p_d = P_BL;
          end else if (c == 8'h2B || c == 8'h2D) begin
            neg_d = (c == 8'h2D);
            p_d   = P_PRE;
          end else begin
            do_pre = 1'b1;
          end
        end
        P_PRE: do_pre = 1'b1;
        P_Z0: begin
          if (isx) begin
            p_d = P_ZX;
          end else if (isdig) begin
            v_d = 33'(dv);
            p_d = P_DIG;
          end else begin
            p_d = P_DONE;
          end
        end
        P_ZX: begin
          if (isdig) begin
            v_d = 33'(dv);
            p_d = P_DIG;
          end else begin
            p_d = P_DONE;
          end
        end
        P_DIG: begin
          if (isdig) v_d = sat;
          else p_d = P_DONE;
        end
        default: p_d = P_DONE;
      endcase
      if (do_pre) begin
        if (req_i.hex && c == 8'h30) begin
          p_d   = P_Z0;
          v_d   = '0;
          any_d = 1'b1;
        end else if (isdig) begin
          v_d   = 33'(dv);
          any_d = 1'b1;
          p_d   = P_DIG;
        end else begin
          p_d = P_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q   <= P_BL;
      v_q   <= '0;
      any_q <= 1'b0;
      neg_q <= 1'b0;
    end else begin
      p_q   <= p_d;
      v_q   <= v_d;
      any_q <= any_d;
      neg_q <= neg_d;
    end
  end

  assign res_o.any   = any_q;
  assign res_o.neg   = neg_q;
  assign res_o.value = v_q;
  assign res_o.ovf   = neg_q ? (v_q > 33'h080000000) : (v_q > 33'h07FFFFFFF);

endmodule

>>> sv/xeu_obuf.sv
// Output stage: holds back one byte so the end flag lands on the last one, then a register.
module xeu_obuf import xeu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  out_req_t   req_i,
  output logic       ok_o,
  output logic [7:0] plain_byte_o,
  output logic       plain_end_o,
  output logic       plain_valid_o,
  input  logic       plain_ready_i
);

  logic       pend_v_q, pend_v_d;
  logic [7:0] pend_q, pend_d;
  logic       out_v_q, out_v_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_end_q, out_end_d;
  logic       out_free, push, push_end;

  assign out_free = !out_v_q || plain_ready_i;
  assign ok_o     = !pend_v_q || out_free;

  always_comb begin
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    push     = 1'b0;
    push_end = 1'b0;
    if (req_i.emit && ok_o) begin
      push     = pend_v_q;
      pend_d   = req_i.data;
      pend_v_d = 1'b1;
    end else if (req_i.flush && ok_o) begin
      push     = pend_v_q;
      push_end = req_i.last;
      pend_v_d = 1'b0;
    end
    out_v_d    = out_v_q;
    out_byte_d = out_byte_q;
    out_end_d  = out_end_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_byte_d = pend_q;
      out_end_d  = push_end;
    end else if (plain_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign plain_byte_o  = out_byte_q;
  assign plain_end_o   = out_end_q;
  assign plain_valid_o = out_v_q;

endmodule

>>> sv/xml_entity_unescape.sv
// Top level: sequencer, entity hold buffer and entity resolution for the XML entity decoder.
// Streaming XML entity decoder. Bytes arrive on the text channel, one request
// at a time; decoded bytes leave on the plain channel through a one-byte
// hold-back stage and an output register, with plain_end on the last byte
// produced by a request carrying text_end. A plain byte passes from one accept
// to the next through accept, feed, end check and flush. A closing ';'
// adds a resolve pass that reads the held body one byte per cycle through the
// shared digit accumulator and then decides; a named entity emits its byte in
// the deciding cycle, other results emit their bytes in the states after it.
// When the tenth byte after '&' arrives with no ';', '&' is emitted in that
// cycle and the held bytes are refed, one per cycle, through the same
// sequencer. End of text inside an entity emits '&' and the held bytes, one
// per cycle. Output stalls hold each emitting step until the output is free.
// The input is not ready while a request is worked.
module xml_entity_unescape import xeu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_byte_i,
  input  logic       text_end_i,
  input  logic       text_valid_i,
  output logic       text_ready_o,
  output logic [7:0] plain_byte_o,
  output logic       plain_end_o,
  output logic       plain_valid_o,
  input  logic       plain_ready_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FEED = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_UTF  = 4'd4;
  localparam logic [3:0] S_RAW  = 4'd5;
  localparam logic [3:0] S_ENDC = 4'd6;
  localparam logic [3:0] S_ENDF = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]       st_q, st_d;
  logic [7:0]       byte_q, byte_d;
  logic             end_q, end_d;
  logic             inside_q, inside_d;
  logic [CNTW-1:0]  hc_q, hc_d, hc_new;
  logic [IDXW-1:0]  rp_q, rp_d;
  logic             resc_q, resc_d;
  logic [KW-1:0]    k_q, k_d, k_m1, hc_k;
  logic [NAMES-1:0] m_q, m_d;
  logic             hash_q, hash_d, hex_q, hex_d;

  logic [7:0]       held_q [SPAN];
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [IDXW-1:0]  rd_idx;
  logic [7:0]       held_rd, fb;

  num_req_t         nreq;
  num_res_t         nres;
  out_req_t         oreq;
  logic             ok;

  logic             hit;
  logic [2:0]       hit_i;
  logic [20:0]      cp;
  logic [2:0]       ulen;
  logic             cp_ok, isx_rd, adv, fin_res;

  xeu_num u_num (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .res_o  (nres)
  );

  xeu_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (oreq),
    .ok_o          (ok),
    .plain_byte_o  (plain_byte_o),
    .plain_end_o   (plain_end_o),
    .plain_valid_o (plain_valid_o),
    .plain_ready_i (plain_ready_i)
  );

  assign k_m1 = k_q - 1'b1;
  assign hc_k = KW'(hc_q);
  assign hc_new = hc_q + 1'b1;

  always_comb begin
    unique case (st_q)
      S_FEED:        rd_idx = rp_q;
      S_SCAN:        rd_idx = k_q[IDXW-1:0];
      S_RAW, S_ENDF: rd_idx = k_m1[IDXW-1:0];
      default:       rd_idx = '0;
    endcase
  end

  assign held_rd = held_q[rd_idx];
  assign fb      = resc_q ? held_rd : byte_q;
  assign isx_rd  = (held_rd == CH_LX) || (held_rd == CH_UX);

  assign cp    = nres.value[20:0];
  assign ulen  = utf8_len(cp);
  assign cp_ok = !nres.neg && (nres.value != '0) && (nres.value < CODE_LIMIT);

  always_comb begin
    hit   = 1'b0;
    hit_i = '0;
    for (int i = NAMES - 1; i >= 0; i--) begin
      if (m_q[i] && hc_k == KW'(name_len(3'(i)))) begin
        hit   = 1'b1;
        hit_i = 3'(i);
      end
    end
  end

  always_comb begin
    st_d     = st_q;
    byte_d   = byte_q;
    end_d    = end_q;
    inside_d = inside_q;
    hc_d     = hc_q;
    rp_d     = rp_q;
    resc_d   = resc_q;
    k_d      = k_q;
    m_d      = m_q;
    hash_d   = hash_q;
    hex_d    = hex_q;
    wr_en    = 1'b0;
    wr_data  = fb;
    nreq     = '{clr: 1'b0, en: 1'b0, hex: hex_q, data: held_rd};
    oreq     = '{emit: 1'b0, flush: 1'b0, last: end_q, data: fb};
    adv      = 1'b0;
    fin_res  = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (text_valid_i) begin
          byte_d = text_byte_i;
          end_d  = text_end_i;
          st_d   = S_FEED;
        end
      end
      S_FEED: begin
        if (!inside_q) begin
          if (fb == CH_AMP) begin
            inside_d = 1'b1;
            hc_d     = '0;
            adv      = 1'b1;
          end else begin
            oreq.emit = 1'b1;
            adv       = ok;
          end
        end else if (fb == CH_SEMI) begin
          st_d     = S_SCAN;
          k_d      = '0;
          m_d      = '1;
          hash_d   = 1'b0;
          hex_d    = 1'b0;
          nreq.clr = 1'b1;
        end else if (hc_new == CNTW'(SPAN)) begin
          oreq.emit = 1'b1;
          oreq.data = CH_AMP;
          if (ok) begin
            wr_en    = 1'b1;
            inside_d = 1'b0;
            hc_d     = '0;
            resc_d   = 1'b1;
            rp_d     = '0;
          end
        end else begin
          wr_en = 1'b1;
          hc_d  = hc_new;
          adv   = 1'b1;
        end
      end
      S_SCAN: begin
        if (k_q == hc_k) begin
          st_d = S_DEC;
        end else begin
          for (int i = 0; i < NAMES; i++) begin
            if (k_q < KW'(name_len(3'(i))))
              m_d[i] = m_q[i] && (held_rd == name_char(3'(i), k_q[1:0]));
            else
              m_d[i] = 1'b0;
          end
          if (k_q == '0) hash_d = (held_rd == CH_HASH);
          if (k_q == KW'(1) && hash_q && isx_rd) hex_d = 1'b1;
          nreq.en = hash_q && (k_q != '0) && !(k_q == KW'(1) && isx_rd);
          k_d     = k_q + 1'b1;
        end
      end
      S_DEC: begin
        k_d = '0;
        if (hit) begin
          oreq.emit = 1'b1;
          oreq.data = name_out(hit_i);
          fin_res   = ok;
        end else if (hash_q) begin
          if (!nres.any || nres.ovf) st_d = S_RAW;
          else if (cp_ok) st_d = S_UTF;
          else fin_res = 1'b1;
        end else begin
          st_d = S_RAW;
        end
      end
      S_UTF: begin
        oreq.emit = 1'b1;
        oreq.data = utf8_byte(cp, ulen, k_q[1:0]);
        if (ok) begin
          if (k_q == KW'(ulen - 3'd1)) fin_res = 1'b1;
          else k_d = k_q + 1'b1;
        end
      end
      S_RAW: begin
        oreq.emit = 1'b1;
        priority if (k_q == '0) oreq.data = CH_AMP;
        else if (k_q == hc_k + 1'b1) oreq.data = CH_SEMI;
        else oreq.data = held_rd;
        if (ok) begin
          if (k_q == hc_k + 1'b1) fin_res = 1'b1;
          else k_d = k_q + 1'b1;
        end
      end
      S_ENDC: begin
        k_d  = '0;
        st_d = (end_q && inside_q) ? S_ENDF : S_FIN;
      end
      S_ENDF: begin
        oreq.emit = 1'b1;
        oreq.data = (k_q == '0) ? CH_AMP : held_rd;
        if (ok) begin
          if (k_q == hc_k) begin
            inside_d = 1'b0;
            hc_d     = '0;
            st_d     = S_FIN;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      S_FIN: begin
        oreq.flush = 1'b1;
        if (ok) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase

    if (fin_res) begin
      inside_d = 1'b0;
      hc_d     = '0;
      adv      = 1'b1;
    end

    if (adv) begin
      if (resc_q) begin
        if (rp_q == IDXW'(SPAN - 1)) begin
          resc_d = 1'b0;
          rp_d   = '0;
          st_d   = S_ENDC;
        end else begin
          rp_d = rp_q + 1'b1;
          st_d = S_FEED;
        end
      end else begin
        st_d = S_ENDC;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      inside_q <= 1'b0;
      hc_q     <= '0;
      rp_q     <= '0;
      resc_q   <= 1'b0;
      k_q      <= '0;
      m_q      <= '0;
      hash_q   <= 1'b0;
      hex_q    <= 1'b0;
      end_q    <= 1'b0;
    end else begin
      st_q     <= st_d;
      inside_q <= inside_d;
      hc_q     <= hc_d;
      rp_q     <= rp_d;
      resc_q   <= resc_d;
      k_q      <= k_d;
      m_q      <= m_d;
      hash_q   <= hash_d;
      hex_q    <= hex_d;
      end_q    <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (wr_en) held_q[hc_q[IDXW-1:0]] <= wr_data;
  end

  assign text_ready_o = (st_q == S_IDLE);

endmodule
